FILE: src/gasp_pkg.sv
// Shared field widths, register indexes and reset values for the glyph atlas shelf packer.
`timescale 1ns / 1ps

package gasp_pkg;

    localparam int GLYPH_W     = 11;
    localparam int ATLAS_OUT_W = 2;
    localparam int POS_X_W     = 11;
    localparam int POS_Y_W     = 10;

    localparam int ROW_HEIGHT_W = 11;
    localparam int GLYPH_GAP_W  = 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_HEIGHT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_GAP  = 2'd1;

    localparam logic [ROW_HEIGHT_W-1:0] ROW_HEIGHT_RST = 11'd64;
    localparam logic [GLYPH_GAP_W-1:0]  GLYPH_GAP_RST  = 8'd2;

endpackage

FILE: src/glyph_atlas_shelf_packer.sv
// Top level of the glyph atlas shelf packer: first-fit shelf scan over a row memory.
`timescale 1ns / 1ps
//
//  Channel  Direction  Handshake              Payload
//  cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//  in       in         in_valid / in_ready    glyph_width
//  out      out        out_valid / out_ready  atlas_index, pos_x, pos_y, opened_row,
//                                             opened_atlas, full_res
//
//  One item is worked on at a time. A glyph wider than an atlas is committed as full.
//  Otherwise the open rows are read one at a time through the single read port of
//  the row memory, and checked for width atlas by atlas; if none fits, the open
//  atlases are searched in turn for room for a new row, else a new atlas is opened
//  if one is left, else the item is full. The commit waits while a result is still
//  held in the output register. Reset clears the atlas and row tables at once; row
//  memory entries are written before they are ever read, so it needs no clearing.

module glyph_atlas_shelf_packer
    import gasp_pkg::*;
#(
    parameter int ATLAS_WIDTH  = 1024,
    parameter int ATLAS_HEIGHT = 1024,
    parameter int MAX_ATLASES  = 4,
    parameter int MAX_ROWS     = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [GLYPH_W-1:0]      glyph_width,

    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ATLAS_OUT_W-1:0]  atlas_index,
    output logic [POS_X_W-1:0]      pos_x,
    output logic [POS_Y_W-1:0]      pos_y,
    output logic                    opened_row,
    output logic                    opened_atlas,
    output logic                    full_res
);

    localparam int FILL_W    = $clog2(ATLAS_WIDTH + 2);
    localparam int TOP_W     = $clog2(ATLAS_HEIGHT + 2);
    localparam int MEM_W     = TOP_W + FILL_W;
    localparam int FIT_W     = $clog2(2 * ATLAS_WIDTH + 2);
    localparam int FSUM_W    = $clog2(2 * ATLAS_WIDTH + 259);
    localparam int TSUM_W    = $clog2(ATLAS_HEIGHT + 2304);
    localparam int ATLAS_W   = (MAX_ATLASES > 1) ? $clog2(MAX_ATLASES) : 1;
    localparam int CNT_W     = $clog2(MAX_ATLASES + 1);
    localparam int ROW_IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int SLOTS     = MAX_ATLASES * MAX_ROWS;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_ROOM = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    // Configuration registers.
    logic [ROW_HEIGHT_W-1:0] row_height_reg;
    logic [GLYPH_GAP_W-1:0]  glyph_gap_reg;

    // Atlas tables.
    logic [CNT_W-1:0]     atlas_count_reg;
    logic [ROW_CNT_W-1:0] rows_reg [MAX_ATLASES];
    logic [TOP_W-1:0]     next_top_reg [MAX_ATLASES];

    // Row memory: {row top, row fill} per slot.
    logic [MEM_W-1:0]  row_mem [SLOTS];
    logic [MEM_W-1:0]  rd_data_reg;
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [MEM_W-1:0]  wr_data;

    // Sequencer.
    logic [1:0]           state_reg, state_next;
    logic [GLYPH_W-1:0]   w_reg, w_next;
    logic [CNT_W-1:0]     a_reg, a_next;
    logic [ROW_CNT_W-1:0] r_reg, r_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [SLOT_W-1:0]    chk_slot_reg, chk_slot_next;
    logic [ATLAS_W-1:0]   chk_atlas_reg, chk_atlas_next;

    // Pending result.
    logic [ATLAS_W-1:0] res_atlas_reg, res_atlas_next;
    logic [SLOT_W-1:0]  res_slot_reg, res_slot_next;
    logic [FILL_W-1:0]  res_fill_reg, res_fill_next;
    logic [TOP_W-1:0]   res_top_reg, res_top_next;
    logic               res_new_row_reg, res_new_row_next;
    logic               res_new_atlas_reg, res_new_atlas_next;
    logic               res_full_reg, res_full_next;

    // Output register.
    logic                   out_valid_reg, out_valid_next;
    logic [ATLAS_OUT_W-1:0] atlas_index_reg;
    logic [POS_X_W-1:0]     pos_x_reg;
    logic [POS_Y_W-1:0]     pos_y_reg;
    logic                   opened_row_reg;
    logic                   opened_atlas_reg;
    logic                   full_res_reg;

    logic [ATLAS_W-1:0]   a_idx;
    logic [ROW_IDX_W-1:0] r_idx;
    logic [SLOT_W-1:0]    scan_slot;
    logic [ROW_CNT_W-1:0] cur_rows;
    logic [TOP_W-1:0]     cur_top;
    logic [FILL_W-1:0]    rd_fill;
    logic [TOP_W-1:0]     rd_top;
    logic [FIT_W-1:0]     fit_sum;
    logic                 hit;
    logic [TSUM_W-1:0]    room_sum;
    logic                 room_ok;
    logic                 row_fits_atlas;
    logic                 accept;
    logic                 commit;
    logic [FSUM_W-1:0]    fill_sum;
    logic [FILL_W-1:0]    fill_new;
    logic [TSUM_W-1:0]    top_sum;
    logic [TOP_W-1:0]     top_new;
    logic [31:0]          atlas_ext;
    logic [31:0]          fill_ext;
    logic [31:0]          top_ext;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign commit    = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign a_idx     = a_reg[ATLAS_W-1:0];
    assign r_idx     = r_reg[ROW_IDX_W-1:0];
    assign scan_slot = SLOT_W'(int'(a_idx) * MAX_ROWS + int'(r_idx));
    assign cur_rows  = rows_reg[a_idx];
    assign cur_top   = next_top_reg[a_idx];

    assign rd_fill = rd_data_reg[FILL_W-1:0];
    assign rd_top  = rd_data_reg[MEM_W-1:FILL_W];
    assign fit_sum = FIT_W'(rd_fill) + FIT_W'(w_reg);
    assign hit     = chk_vld_reg && (fit_sum <= FIT_W'(ATLAS_WIDTH));

    assign room_sum       = TSUM_W'(cur_top) + TSUM_W'(row_height_reg);
    assign room_ok        = (cur_rows < ROW_CNT_W'(MAX_ROWS))
                            && (room_sum <= TSUM_W'(ATLAS_HEIGHT));
    assign row_fits_atlas = (TSUM_W'(row_height_reg) <= TSUM_W'(ATLAS_HEIGHT));

    // Both counters saturate one above their limit, which fails every later fit test.
    assign fill_sum = FSUM_W'(res_fill_reg) + FSUM_W'(w_reg) + FSUM_W'(glyph_gap_reg);
    assign fill_new = (fill_sum > FSUM_W'(ATLAS_WIDTH)) ? FILL_W'(ATLAS_WIDTH + 1)
                                                        : fill_sum[FILL_W-1:0];
    assign top_sum  = TSUM_W'(res_top_reg) + TSUM_W'(row_height_reg)
                      + TSUM_W'(glyph_gap_reg);
    assign top_new  = (top_sum > TSUM_W'(ATLAS_HEIGHT)) ? TOP_W'(ATLAS_HEIGHT + 1)
                                                        : top_sum[TOP_W-1:0];

    assign wr_en   = commit && !res_full_reg;
    assign wr_data = {res_top_reg, fill_new};

    assign atlas_ext = 32'(res_atlas_reg);
    assign fill_ext  = 32'(res_fill_reg);
    assign top_ext   = 32'(res_top_reg);

    always_comb
    begin
        state_next         = state_reg;
        w_next             = w_reg;
        a_next             = a_reg;
        r_next             = r_reg;
        chk_vld_next       = chk_vld_reg;
        chk_slot_next      = chk_slot_reg;
        chk_atlas_next     = chk_atlas_reg;
        res_atlas_next     = res_atlas_reg;
        res_slot_next      = res_slot_reg;
        res_fill_next      = res_fill_reg;
        res_top_next       = res_top_reg;
        res_new_row_next   = res_new_row_reg;
        res_new_atlas_next = res_new_atlas_reg;
        res_full_next      = res_full_reg;
        rd_en              = 1'b0;
        rd_addr            = scan_slot;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    w_next             = glyph_width;
                    a_next             = '0;
                    r_next             = '0;
                    chk_vld_next       = 1'b0;
                    res_atlas_next     = '0;
                    res_slot_next      = '0;
                    res_fill_next      = '0;
                    res_top_next       = '0;
                    res_new_row_next   = 1'b0;
                    res_new_atlas_next = 1'b0;
                    res_full_next      = 1'b0;
                    if (32'(glyph_width) > 32'(ATLAS_WIDTH))
                    begin
                        res_full_next = 1'b1;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // Reads are issued back to back; each one is checked in the cycle after it is issued.
                if (hit)
                begin
                    chk_vld_next   = 1'b0;
                    res_atlas_next = chk_atlas_reg;
                    res_slot_next  = chk_slot_reg;
                    res_fill_next  = rd_fill;
                    res_top_next   = rd_top;
                    state_next     = S_DONE;
                end
                else if (a_reg < atlas_count_reg)
                begin
                    if (r_reg < cur_rows)
                    begin
                        rd_en          = 1'b1;
                        chk_vld_next   = 1'b1;
                        chk_slot_next  = scan_slot;
                        chk_atlas_next = a_idx;
                        r_next         = r_reg + ROW_CNT_W'(1);
                    end
                    else
                    begin
                        chk_vld_next = 1'b0;
                        a_next       = a_reg + CNT_W'(1);
                        r_next       = '0;
                    end
                end
                else
                begin
                    chk_vld_next = 1'b0;
                    if (!chk_vld_reg)
                    begin
                        a_next     = '0;
                        state_next = S_ROOM;
                    end
                end
            end

            S_ROOM:
            begin
                if (a_reg < atlas_count_reg)
                begin
                    if (room_ok)
                    begin
                        res_atlas_next   = a_idx;
                        res_slot_next    = SLOT_W'(int'(a_idx) * MAX_ROWS
                                                   + int'(cur_rows[ROW_IDX_W-1:0]));
                        res_fill_next    = '0;
                        res_top_next     = cur_top;
                        res_new_row_next = 1'b1;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        a_next = a_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if ((atlas_count_reg < CNT_W'(MAX_ATLASES)) && row_fits_atlas)
                    begin
                        res_atlas_next     = atlas_count_reg[ATLAS_W-1:0];
                        res_slot_next      = SLOT_W'(int'(atlas_count_reg[ATLAS_W-1:0])
                                                     * MAX_ROWS);
                        res_fill_next      = '0;
                        res_top_next       = '0;
                        res_new_row_next   = 1'b1;
                        res_new_atlas_next = 1'b1;
                    end
                    else
                    begin
                        res_full_next = 1'b1;
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state and tables.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            chk_vld_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            row_height_reg  <= ROW_HEIGHT_RST;
            glyph_gap_reg   <= GLYPH_GAP_RST;
            atlas_count_reg <= '0;
            for (int i = 0; i < MAX_ATLASES; i++)
            begin
                rows_reg[i]     <= '0;
                next_top_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ROW_HEIGHT: row_height_reg <= cfg_data[ROW_HEIGHT_W-1:0];
                    REG_GLYPH_GAP:  glyph_gap_reg  <= cfg_data[GLYPH_GAP_W-1:0];
                    default:        ;
                endcase
            end

            if (wr_en && res_new_row_reg)
            begin
                rows_reg[res_atlas_reg]     <= rows_reg[res_atlas_reg] + ROW_CNT_W'(1);
                next_top_reg[res_atlas_reg] <= top_new;
            end
            if (wr_en && res_new_atlas_reg)
            begin
                atlas_count_reg <= atlas_count_reg + CNT_W'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        w_reg             <= w_next;
        a_reg             <= a_next;
        r_reg             <= r_next;
        chk_slot_reg      <= chk_slot_next;
        chk_atlas_reg     <= chk_atlas_next;
        res_atlas_reg     <= res_atlas_next;
        res_slot_reg      <= res_slot_next;
        res_fill_reg      <= res_fill_next;
        res_top_reg       <= res_top_next;
        res_new_row_reg   <= res_new_row_next;
        res_new_atlas_reg <= res_new_atlas_next;
        res_full_reg      <= res_full_next;
        if (commit)
        begin
            atlas_index_reg  <= atlas_ext[ATLAS_OUT_W-1:0];
            pos_x_reg        <= fill_ext[POS_X_W-1:0];
            pos_y_reg        <= top_ext[POS_Y_W-1:0];
            opened_row_reg   <= res_new_row_reg;
            opened_atlas_reg <= res_new_atlas_reg;
            full_res_reg     <= res_full_reg;
        end
    end

    // Row memory. A row is written at commit, before the next item can read it.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[res_slot_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    assign out_valid    = out_valid_reg;
    assign atlas_index  = atlas_index_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign opened_row   = opened_row_reg;
    assign opened_atlas = opened_atlas_reg;
    assign full_res     = full_res_reg;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the glyph atlas shelf packer: random and directed glyph placement.
`timescale 1ns / 1ps

module testbench;
    import gasp_pkg::*;

    localparam int ATLAS_W      = 1024;
    localparam int ATLAS_H      = 1024;
    localparam int N_ATLAS      = 4;
    localparam int N_ROWS       = 16;
    localparam int N_PHASES     = 9;
    localparam int PHASE_ITEMS  = 194;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 1000000;

    // Indexes the block has no register for; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [ATLAS_OUT_W-1:0] atlas;
        logic [POS_X_W-1:0]     x;
        logic [POS_Y_W-1:0]     y;
        logic                   opened_row;
        logic                   opened_atlas;
        logic                   full;
    } placement_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [GLYPH_W-1:0]     glyph_width = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [ATLAS_OUT_W-1:0] atlas_index;
    logic [POS_X_W-1:0]     pos_x;
    logic [POS_Y_W-1:0]     pos_y;
    logic                   opened_row;
    logic                   opened_atlas;
    logic                   full_res;

    glyph_atlas_shelf_packer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .glyph_width  (glyph_width),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .atlas_index  (atlas_index),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .opened_row   (opened_row),
        .opened_atlas (opened_atlas),
        .full_res     (full_res)
    );

    always #5 clk = ~clk;

    // Shadow copy of the packer's tables and registers.
    logic [ROW_HEIGHT_W-1:0] shadow_row_height = ROW_HEIGHT_RST;
    logic [GLYPH_GAP_W-1:0]  shadow_gap = GLYPH_GAP_RST;
    int unsigned             pages_open = 0;
    int unsigned             shelf_count [N_ATLAS] = '{default: 0};
    logic [11:0]             shelf_next_top [N_ATLAS] = '{default: '0};
    logic [11:0]             shelf_fill [N_ATLAS*N_ROWS] = '{default: '0};
    logic [11:0]             shelf_top [N_ATLAS*N_ROWS] = '{default: '0};

    logic [GLYPH_W-1:0] pending_widths [$];
    placement_t         expected_placements [$];

    int unsigned tx_idle_pct = 0;
    int unsigned rx_idle_pct = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    logic        hold_go = 1'b0;
    logic        hold_done = 1'b0;
    int unsigned hold_cycles = 0;
    wire         rx_hold = hold_go && !hold_done;

    int unsigned phase_height [N_PHASES] = '{500, 2047, 1, 1024, 64, 0, 30, 1025, 0};
    int unsigned phase_gap [N_PHASES] = '{16, 255, 0, 0, 2, 255, 4, 1, 0};

    function automatic logic [11:0] sat_sum(input int unsigned base, input int unsigned step,
                                            input int unsigned limit);
        return (base + step > limit) ? 12'(limit + 1) : 12'(base + step);
    endfunction

    // First-fit shelf placement: existing rows first, then a new row, then a new atlas.
    function automatic placement_t place_glyph(input logic [GLYPH_W-1:0] w);
        placement_t  res;
        int unsigned a;
        int unsigned r;
        int unsigned slot;
        int unsigned page;
        bit          found;
        bit          new_row;
        bit          new_page;
        res = '0;
        slot = 0;
        page = 0;
        found = 1'b0;
        new_row = 1'b0;
        new_page = 1'b0;
        if (w <= ATLAS_W) begin
            for (a = 0; a < pages_open && !found; a++) begin
                for (r = 0; r < shelf_count[a] && !found; r++) begin
                    if (shelf_fill[a*N_ROWS + r] + w <= ATLAS_W) begin
                        page = a;
                        slot = a*N_ROWS + r;
                        found = 1'b1;
                    end
                end
            end
            for (a = 0; a < pages_open && !found; a++) begin
                if (shelf_count[a] < N_ROWS &&
                    shelf_next_top[a] + shadow_row_height <= ATLAS_H) begin
                    page = a;
                    found = 1'b1;
                    new_row = 1'b1;
                end
            end
            if (!found && pages_open < N_ATLAS && shadow_row_height <= ATLAS_H) begin
                page = pages_open;
                pages_open++;
                shelf_count[page] = 0;
                shelf_next_top[page] = '0;
                found = 1'b1;
                new_row = 1'b1;
                new_page = 1'b1;
            end
        end
        if (!found) begin
            res.full = 1'b1;
            return res;
        end
        if (new_row) begin
            slot = page*N_ROWS + shelf_count[page];
            shelf_count[page]++;
            shelf_fill[slot] = '0;
            shelf_top[slot] = shelf_next_top[page];
            shelf_next_top[page] = sat_sum(shelf_next_top[page],
                                           shadow_row_height + shadow_gap, ATLAS_H);
        end
        res.atlas = page[ATLAS_OUT_W-1:0];
        res.x = shelf_fill[slot][POS_X_W-1:0];
        res.y = shelf_top[slot][POS_Y_W-1:0];
        res.opened_row = new_row;
        res.opened_atlas = new_page;
        shelf_fill[slot] = sat_sum(shelf_fill[slot], w + shadow_gap, ATLAS_W);
        return res;
    endfunction

    function automatic logic [GLYPH_W-1:0] random_width();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return GLYPH_W'($urandom_range(48));
        else if (pick < 80)
            return GLYPH_W'($urandom_range(1024, 49));
        else if (pick < 90) begin
            case ($urandom_range(4))
                0:       return GLYPH_W'(0);
                1:       return GLYPH_W'(1023);
                2:       return GLYPH_W'(1024);
                3:       return GLYPH_W'(1025);
                default: return GLYPH_W'(2047);
            endcase
        end
        return GLYPH_W'($urandom);
    endfunction

    task automatic check_field(input string name, input logic [10:0] want,
                               input logic [10:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // Driver: offers queued glyph widths and predicts the placement of each accepted item.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && in_ready)
                expected_placements.push_back(place_glyph(glyph_width));
            if (!in_valid || in_ready) begin
                if (pending_widths.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    in_valid <= 1'b1;
                    glyph_width <= pending_widths.pop_front();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares every accepted result with the oldest predicted placement.
    always @(posedge clk) begin
        placement_t want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_placements.size() == 0) begin
                    $display("%0t ns: result with no item waiting for it", $time);
                    error_count++;
                end
                else begin
                    want = expected_placements.pop_front();
                    check_field("atlas_index", 11'(want.atlas), 11'(atlas_index));
                    check_field("pos_x", 11'(want.x), 11'(pos_x));
                    check_field("pos_y", 11'(want.y), 11'(pos_y));
                    check_field("opened_row", 11'(want.opened_row), 11'(opened_row));
                    check_field("opened_atlas", 11'(want.opened_atlas), 11'(opened_atlas));
                    check_field("full_res", 11'(want.full), 11'(full_res));
                end
            end
            out_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    always @(posedge clk) begin
        if (rx_hold) begin
            if (hold_cycles == HOLD_CYCLES - 1)
                hold_done <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL glyph_atlas_shelf_packer");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx == REG_ROW_HEIGHT)
            shadow_row_height = data;
        else if (idx == REG_GLYPH_GAP)
            shadow_gap = data[GLYPH_GAP_W-1:0];
    endtask

    // Returns at a falling edge once every item is accepted and every result has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_widths.size() != 0 || in_valid || expected_placements.size() != 0);
    endtask

    initial begin
        int unsigned phase;
        int unsigned mode;
        int unsigned i;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        tx_idle_pct = 13;
        rx_idle_pct = 49;

        // Reset settings: empty tables, exact fits, glyphs wider than a page.
        pending_widths.push_back(11'd0);
        pending_widths.push_back(11'd1024);
        pending_widths.push_back(11'd1025);
        pending_widths.push_back(11'd2047);
        pending_widths.push_back(11'd1);
        pending_widths.push_back(11'd1021);
        pending_widths.push_back(11'd512);
        pending_widths.push_back(11'd512);
        wait_drained();

        // Row taller than a page; gap data wider than the register; spare indexes.
        write_reg(REG_ROW_HEIGHT, 11'd2047);
        write_reg(REG_GLYPH_GAP, 11'd300);
        write_reg(REG_SPARE_A, 11'h7FF);
        write_reg(REG_SPARE_B, 11'h000);
        @(negedge clk);
        pending_widths.push_back(11'd1024);
        pending_widths.push_back(11'd0);
        wait_drained();

        // Full-height rows with the widest gap drive the fill and top counters into saturation.
        write_reg(REG_ROW_HEIGHT, 11'd1024);
        write_reg(REG_GLYPH_GAP, 11'd255);
        @(negedge clk);
        pending_widths.push_back(11'd1000);
        pending_widths.push_back(11'd24);
        pending_widths.push_back(11'd0);
        wait_drained();

        write_reg(REG_ROW_HEIGHT, 11'd0);
        write_reg(REG_GLYPH_GAP, 11'd0);
        @(negedge clk);
        pending_widths.push_back(11'd1024);
        pending_widths.push_back(11'd1024);
        pending_widths.push_back(11'd0);
        wait_drained();

        for (phase = 0; phase < N_PHASES; phase++) begin
            mode = phase / 3;
            if (phase == N_PHASES - 1) begin
                phase_height[phase] = $urandom_range(1100);
                phase_gap[phase] = $urandom_range(255);
            end
            write_reg(REG_ROW_HEIGHT, CFG_DATA_W'(phase_height[phase]));
            write_reg(REG_GLYPH_GAP, {3'($urandom), 8'(phase_gap[phase])});
            write_reg((phase % 2 == 0) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
            @(negedge clk);
            tx_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 49 : 0;
            rx_idle_pct = (mode == 0) ? 49 : (mode == 1) ? 13 : 0;
            if (phase == 6)
                hold_go = 1'b1;
            for (i = 0; i < PHASE_ITEMS; i++)
                pending_widths.push_back(random_width());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_placements.size() == 0)
            $display("PASS glyph_atlas_shelf_packer");
        else
            $display("FAIL glyph_atlas_shelf_packer");
        $finish;
    end

endmodule
